// ===== rtl/lmbs_pkg.sv =====
// Shared constants, codes and transfer types of the LED matrix blink scanner.
package lmbs_pkg;

	localparam int ROWS  = 3;
	localparam int COLS  = 3;
	localparam int NCELL = ROWS * COLS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam int DIV_W   = 9;
	localparam int DIVCNT_W = $clog2(DIV_W);

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_ON     = 3'd1;
	localparam logic [2:0] OP_OFF    = 3'd2;
	localparam logic [2:0] OP_TOGGLE = 3'd3;
	localparam logic [2:0] OP_BLINK  = 3'd4;
	localparam logic [2:0] OP_STOP   = 3'd5;

	localparam logic [DIV_W-1:0] FREQ_BASE     = DIV_W'(1000 / 2);
	localparam logic [7:0]       PRESCALE_INIT = 8'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_FREQ,
		S_DIV_PRE,
		S_CHAIN,
		S_OUT
	} lmbs_state_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [2:0] led_row;
		logic [2:0] led_col;
		logic [8:0] blink_freq;
	} lmbs_in_t;

	typedef struct packed {
		logic [7:0] row_drive;
		logic [7:0] col_drive;
		logic       pins_refreshed;
		logic       addressed_blinking;
	} lmbs_out_t;

	typedef struct packed {
		logic             valid;
		logic [2:0]       op;
		logic [2:0]       row;
		logic [2:0]       col;
		logic [DIV_W-1:0] reload;
		logic             refresh;
		logic             blinking;
	} lmbs_pkt_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} lmbs_div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} lmbs_div_sts_t;

endpackage

// ===== rtl/lmbs_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module lmbs_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lmbs_pkg::lmbs_div_req_t req,
	output lmbs_pkg::lmbs_div_sts_t sts
);

	logic [lmbs_pkg::DIV_W-1:0]    rem_q;
	logic [lmbs_pkg::DIV_W-1:0]    quo_q;
	logic [lmbs_pkg::DIV_W-1:0]    divisor_q;
	logic [lmbs_pkg::DIVCNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [lmbs_pkg::DIV_W:0]   trial;
	logic                       ge;
	logic [lmbs_pkg::DIV_W-1:0] rem_d;

	always_comb begin
		trial = {rem_q, quo_q[lmbs_pkg::DIV_W-1]};
		ge    = trial >= {1'b0, divisor_q};
		rem_d = ge ? lmbs_pkg::DIV_W'(trial - {1'b0, divisor_q})
		           : lmbs_pkg::DIV_W'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lmbs_pkg::DIVCNT_W'(lmbs_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= {quo_q[lmbs_pkg::DIV_W-2:0], ge};
		end
	end

	assign sts.busy     = busy_q;
	assign sts.done     = done_q;
	assign sts.quotient = quo_q;

endmodule

// ===== rtl/lmbs_cell.sv =====
// One LED of the matrix: lit bit, blink mode and blink counters, one chain stage.
module lmbs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          cell_row,
	input  logic [2:0]          cell_col,
	input  lmbs_pkg::lmbs_pkt_t pkt_in,
	output lmbs_pkg::lmbs_pkt_t pkt_out,
	output logic                lit
);

	logic                       lit_q;
	logic                       mode_q;
	logic [lmbs_pkg::DIV_W-1:0] reload_q;
	logic [lmbs_pkg::DIV_W-1:0] count_q;
	lmbs_pkg::lmbs_pkt_t        pkt_q;

	logic                       match;
	logic                       blink_now;
	logic [lmbs_pkg::DIV_W-1:0] dec;
	logic                       lit_d;
	logic                       mode_d;
	logic [lmbs_pkg::DIV_W-1:0] reload_d;
	logic [lmbs_pkg::DIV_W-1:0] count_d;
	lmbs_pkg::lmbs_pkt_t        pkt_d;

	always_comb begin
		match     = pkt_in.valid && (pkt_in.row == cell_row) && (pkt_in.col == cell_col);
		blink_now = pkt_in.valid && pkt_in.refresh && mode_q;
		dec       = count_q - 1'b1;
		lit_d     = lit_q;
		mode_d    = mode_q;
		reload_d  = reload_q;
		count_d   = count_q;
		if (blink_now) begin
			if (dec == '0) begin
				lit_d   = ~lit_q;
				count_d = reload_q;
			end else begin
				count_d = dec;
			end
		end
		if (match) begin
			unique case (pkt_in.op)
				lmbs_pkg::OP_ON: begin
					lit_d = 1'b1;
				end
				lmbs_pkg::OP_OFF: begin
					lit_d = 1'b0;
				end
				lmbs_pkg::OP_TOGGLE: begin
					lit_d = ~lit_q;
				end
				lmbs_pkg::OP_BLINK: begin
					mode_d   = 1'b1;
					reload_d = pkt_in.reload;
					count_d  = pkt_in.reload;
				end
				lmbs_pkg::OP_STOP: begin
					mode_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
		pkt_d          = pkt_in;
		pkt_d.blinking = pkt_in.blinking | (match & mode_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q  <= 1'b0;
			mode_q <= 1'b0;
			pkt_q  <= '0;
		end else begin
			lit_q  <= lit_d;
			mode_q <= mode_d;
			pkt_q  <= pkt_d;
		end
	end

	always_ff @(posedge clk) begin
		reload_q <= reload_d;
		count_q  <= count_d;
	end

	assign pkt_out = pkt_q;
	assign lit     = lit_q;

endmodule

// ===== rtl/led_matrix_blink_scanner.sv =====
// Top level of the LED matrix blink scanner: control, prescaler, cell chain and pins.
// A tick or LED command walks the cell chain from transfer to result; start blink first
// runs two 9-bit divides, frequency then prescale. Only one item is in flight: a new
// item is taken once the last has walked the chain and been moved to the output.
// The next item transfers while a result waits on the output.
// Reset: LEDs off, no blinking, row counter, prescale count and pins zero, prescale 5.
module led_matrix_blink_scanner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lmbs_pkg::lmbs_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lmbs_pkg::lmbs_out_t out_data,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);

	lmbs_pkg::lmbs_state_t state_q;
	lmbs_pkg::lmbs_state_t state_d;

	lmbs_pkg::lmbs_in_t          in_q;
	logic [7:0]                  prescale_q;
	logic [7:0]                  pcount_q;
	logic [lmbs_pkg::ROW_W-1:0]  scan_row_q;
	logic [7:0]                  drv_row_q;
	logic [7:0]                  drv_col_q;
	logic                        refresh_q;
	logic                        blink_q;
	logic                        out_valid_q;
	lmbs_pkg::lmbs_out_t         out_q;

	lmbs_pkg::lmbs_div_req_t div_req;
	lmbs_pkg::lmbs_div_sts_t div_sts;

	lmbs_pkg::lmbs_pkt_t pkt_head;
	lmbs_pkg::lmbs_pkt_t pkt [0:lmbs_pkg::NCELL];
	logic [lmbs_pkg::NCELL-1:0] lit;

	logic                        accept;
	logic                        slot_free;
	logic [7:0]                  pre;
	logic [8:0]                  cnt_next;
	logic                        tick_refresh;
	logic [lmbs_pkg::DIV_W-1:0]  freq_div;
	logic [lmbs_pkg::DIV_W-1:0]  reload_clamped;
	logic [7:0]                  row_lit;
	lmbs_pkg::lmbs_pkt_t         last;

	assign pkt[0]    = pkt_head;
	assign last      = pkt[lmbs_pkg::NCELL];
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		pre            = (prescale_q == 8'd0) ? 8'd1 : prescale_q;
		cnt_next       = {1'b0, pcount_q} + 9'd1;
		tick_refresh   = (in_data.opcode == lmbs_pkg::OP_TICK) && (cnt_next >= {1'b0, pre});
		freq_div       = (in_data.blink_freq == '0) ? lmbs_pkg::DIV_W'(1) : in_data.blink_freq;
		reload_clamped = (div_sts.quotient == '0) ? lmbs_pkg::DIV_W'(1) : div_sts.quotient;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		div_req  = '0;
		pkt_head = '0;
		unique case (state_q)
			lmbs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_data.opcode == lmbs_pkg::OP_BLINK) begin
						div_req.start    = 1'b1;
						div_req.dividend = lmbs_pkg::FREQ_BASE;
						div_req.divisor  = freq_div;
						state_d          = lmbs_pkg::S_DIV_FREQ;
					end else begin
						pkt_head.valid   = 1'b1;
						pkt_head.op      = in_data.opcode;
						pkt_head.row     = in_data.led_row;
						pkt_head.col     = in_data.led_col;
						pkt_head.refresh = tick_refresh;
						state_d          = lmbs_pkg::S_CHAIN;
					end
				end
			end
			lmbs_pkg::S_DIV_FREQ: begin
				if (div_sts.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = div_sts.quotient;
					div_req.divisor  = {1'b0, pre};
					state_d          = lmbs_pkg::S_DIV_PRE;
				end
			end
			lmbs_pkg::S_DIV_PRE: begin
				if (div_sts.done) begin
					pkt_head.valid  = 1'b1;
					pkt_head.op     = in_q.opcode;
					pkt_head.row    = in_q.led_row;
					pkt_head.col    = in_q.led_col;
					pkt_head.reload = reload_clamped;
					state_d         = lmbs_pkg::S_CHAIN;
				end
			end
			lmbs_pkg::S_CHAIN: begin
				if (last.valid) begin
					state_d = lmbs_pkg::S_OUT;
				end
			end
			lmbs_pkg::S_OUT: begin
				if (slot_free) begin
					state_d = lmbs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lmbs_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmbs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	lmbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	for (genvar k = 0; k < lmbs_pkg::NCELL; k++) begin : g_cell
		lmbs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_row (3'(k / lmbs_pkg::COLS)),
			.cell_col (3'(k % lmbs_pkg::COLS)),
			.pkt_in   (pkt[k]),
			.pkt_out  (pkt[k+1]),
			.lit      (lit[k])
		);
	end

	always_comb begin
		row_lit = '0;
		for (int r = 0; r < lmbs_pkg::ROWS; r++) begin
			if (scan_row_q == lmbs_pkg::ROW_W'(r)) begin
				for (int c = 0; c < lmbs_pkg::COLS; c++) begin
					row_lit[c] = lit[r * lmbs_pkg::COLS + c];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q  <= lmbs_pkg::PRESCALE_INIT;
			pcount_q    <= '0;
			scan_row_q  <= '0;
			drv_row_q   <= '0;
			drv_col_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				prescale_q <= cfg_wdata;
			end
			if (accept && (in_data.opcode == lmbs_pkg::OP_TICK)) begin
				pcount_q <= tick_refresh ? 8'd0 : cnt_next[7:0];
			end
			if (state_q == lmbs_pkg::S_CHAIN && last.valid && last.refresh) begin
				drv_row_q <= 8'd1 << scan_row_q;
				drv_col_q <= ~row_lit;
				if (scan_row_q == lmbs_pkg::ROW_W'(lmbs_pkg::ROWS - 1)) begin
					scan_row_q <= '0;
				end else begin
					scan_row_q <= scan_row_q + 1'b1;
				end
			end
			if (state_q == lmbs_pkg::S_OUT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_data;
		end
		if (state_q == lmbs_pkg::S_CHAIN && last.valid) begin
			refresh_q <= last.refresh;
			blink_q   <= last.blinking;
		end
		if (state_q == lmbs_pkg::S_OUT && slot_free) begin
			out_q.row_drive          <= drv_row_q;
			out_q.col_drive          <= drv_col_q;
			out_q.pins_refreshed     <= refresh_q;
			out_q.addressed_blinking <= blink_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic [lmbs_pkg::NCELL:0] pkt_valids;
	always_comb begin
		for (int k = 0; k <= lmbs_pkg::NCELL; k++) begin
			pkt_valids[k] = pkt[k].valid;
		end
	end

	a_refresh_row_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pins_refreshed |-> $onehot(out_data.row_drive))
		else $error("refreshed result without a one-hot row");

	a_chain_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pkt_valids))
		else $error("more than one item walking the cell chain");

	a_blink_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		last.valid && last.blinking |->
			(last.row < lmbs_pkg::ROWS) && (last.col < lmbs_pkg::COLS))
		else $error("blink mode reported for an address outside the matrix");

	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_sts.busy)
		else $error("divider started while busy");

endmodule

// ===== dv/tb.sv =====
// Testbench of the LED matrix blink scanner: directed and random items against a matrix mirror.
module tb;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int LONG_HOLD      = 120;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	lmbs_pkg::lmbs_in_t  in_data;
	logic                out_valid;
	logic                out_ready;
	lmbs_pkg::lmbs_out_t out_data;
	logic                cfg_we;
	logic [7:0]          cfg_wdata;

	lmbs_pkg::lmbs_out_t expected_pins[$];
	int        errors      = 0;
	int        idle_cycles = 0;
	int        rx_hold     = 0;
	bit        quiet       = 1'b0;

	logic [7:0] m_lit [lmbs_pkg::ROWS];
	logic       m_blink [lmbs_pkg::ROWS][lmbs_pkg::COLS];
	logic [8:0] m_reload [lmbs_pkg::ROWS][lmbs_pkg::COLS];
	logic [8:0] m_count [lmbs_pkg::ROWS][lmbs_pkg::COLS];
	int         m_scan;
	logic [7:0] m_precnt;
	logic [7:0] m_prescale;
	logic [7:0] m_row_pins;
	logic [7:0] m_col_pins;

	led_matrix_blink_scanner uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic lmbs_pkg::lmbs_out_t advance_matrix(input lmbs_pkg::lmbs_in_t it);
		lmbs_pkg::lmbs_out_t res;
		logic      hit;
		int        pre;
		int        f;
		int        reload;
		hit = (it.led_row < lmbs_pkg::ROWS) && (it.led_col < lmbs_pkg::COLS);
		pre = (m_prescale == 8'd0) ? 1 : int'(m_prescale);
		res = '0;
		if (it.opcode == lmbs_pkg::OP_TICK) begin
			if (int'(m_precnt) + 1 >= pre) begin
				m_precnt = 8'd0;
				for (int r = 0; r < lmbs_pkg::ROWS; r++) begin
					for (int c = 0; c < lmbs_pkg::COLS; c++) begin
						if (m_blink[r][c]) begin
							m_count[r][c] = m_count[r][c] - 9'd1;
							if (m_count[r][c] == 9'd0) begin
								m_lit[r][c]   = ~m_lit[r][c];
								m_count[r][c] = m_reload[r][c];
							end
						end
					end
				end
				m_row_pins = 8'(1 << m_scan);
				m_col_pins = ~m_lit[m_scan];
				m_scan     = (m_scan + 1) % lmbs_pkg::ROWS;
				res.pins_refreshed = 1'b1;
			end else begin
				m_precnt = m_precnt + 8'd1;
			end
		end else if (hit) begin
			case (it.opcode)
				lmbs_pkg::OP_ON:     m_lit[it.led_row][it.led_col] = 1'b1;
				lmbs_pkg::OP_OFF:    m_lit[it.led_row][it.led_col] = 1'b0;
				lmbs_pkg::OP_TOGGLE: m_lit[it.led_row][it.led_col] = ~m_lit[it.led_row][it.led_col];
				lmbs_pkg::OP_BLINK: begin
					f      = (it.blink_freq == 9'd0) ? 1 : int'(it.blink_freq);
					reload = (int'(lmbs_pkg::FREQ_BASE) / f) / pre;
					if (reload == 0)
						reload = 1;
					m_blink[it.led_row][it.led_col]  = 1'b1;
					m_reload[it.led_row][it.led_col] = 9'(reload);
					m_count[it.led_row][it.led_col]  = 9'(reload);
				end
				lmbs_pkg::OP_STOP:   m_blink[it.led_row][it.led_col] = 1'b0;
				default:   ;
			endcase
		end
		if (hit)
			res.addressed_blinking = m_blink[it.led_row][it.led_col];
		res.row_drive = m_row_pins;
		res.col_drive = m_col_pins;
		return res;
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		lmbs_pkg::lmbs_out_t want;
		if (out_valid && out_ready) begin
			if (expected_pins.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual %h",
					$time, out_data);
				errors++;
			end else begin
				want = expected_pins.pop_front();
				compare_field("row_drive", want.row_drive, out_data.row_drive);
				compare_field("col_drive", want.col_drive, out_data.col_drive);
				compare_field("pins_refreshed", want.pins_refreshed, out_data.pins_refreshed);
				compare_field("addressed_blinking", want.addressed_blinking,
					out_data.addressed_blinking);
			end
		end
		if (in_valid && in_ready)
			expected_pins.push_back(advance_matrix(in_data));
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, no transfer for %0d cycles", $time, idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// receiver: random short stalls, or a long hold when requested
	initial begin
		int n;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				n       = rx_hold;
				rx_hold = 0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 3);
			end else begin
				n = 0;
			end
			if (n > 0) begin
				out_ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	function automatic lmbs_pkg::lmbs_in_t make_item(input logic [2:0] op,
			input logic [2:0] row, input logic [2:0] col, input logic [8:0] freq);
		lmbs_pkg::lmbs_in_t it;
		it.opcode     = op;
		it.led_row    = row;
		it.led_col    = col;
		it.blink_freq = freq;
		return it;
	endfunction

	function automatic lmbs_pkg::lmbs_in_t random_item();
		lmbs_pkg::lmbs_in_t it;
		logic [17:0] raw;
		int          pick;
		pick       = $urandom_range(0, 99);
		it.led_row = 3'($urandom_range(0, lmbs_pkg::ROWS - 1));
		it.led_col = 3'($urandom_range(0, lmbs_pkg::COLS - 1));
		if ($urandom_range(0, 3) == 0)
			it.blink_freq = 9'($urandom_range(0, 511));
		else
			it.blink_freq = 9'($urandom_range(80, 500));
		if (pick < 55) begin
			it.opcode = lmbs_pkg::OP_TICK;
		end else if (pick < 90) begin
			case ($urandom_range(0, 5))
				0, 1: it.opcode = lmbs_pkg::OP_BLINK;
				2:    it.opcode = lmbs_pkg::OP_ON;
				3:    it.opcode = lmbs_pkg::OP_OFF;
				4:    it.opcode = lmbs_pkg::OP_TOGGLE;
				default: it.opcode = lmbs_pkg::OP_STOP;
			endcase
		end else begin
			raw = 18'($urandom);
			it  = raw;
		end
		return it;
	endfunction

	task automatic send_item(input lmbs_pkg::lmbs_in_t item);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_data  = item;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_pins.size() != 0) @(negedge clk);
	endtask

	task automatic write_prescale(input logic [7:0] value);
		wait_drained();
		cfg_we     = 1'b1;
		cfg_wdata  = value;
		m_prescale = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] prescale, input int count);
		write_prescale(prescale);
		for (int i = 0; i < count; i++)
			send_item(random_item());
	endtask

	task automatic test_led_commands();
		send_item(make_item(lmbs_pkg::OP_ON, 3'd0, 3'd0, 9'd0));
		send_item(make_item(lmbs_pkg::OP_ON, 3'd2, 3'd2, 9'h1FF));
		send_item(make_item(lmbs_pkg::OP_TOGGLE, 3'd1, 3'd2, 9'd0));
		send_item(make_item(lmbs_pkg::OP_TOGGLE, 3'd1, 3'd2, 9'd0));
		send_item(make_item(lmbs_pkg::OP_OFF, 3'd2, 3'd2, 9'd0));
		// out-of-range addresses are ignored
		send_item(make_item(lmbs_pkg::OP_ON, 3'd7, 3'd0, 9'd0));
		send_item(make_item(lmbs_pkg::OP_ON, 3'd0, 3'd7, 9'd0));
		send_item(make_item(lmbs_pkg::OP_BLINK, 3'd3, 3'd3, 9'd100));
		send_item(make_item(OP_SPARE_A, 3'd0, 3'd0, 9'd0));
		send_item(make_item(OP_SPARE_B, 3'd7, 3'd7, 9'h1FF));
		// zero frequency counts as one hertz; high frequency clamps the reload
		send_item(make_item(lmbs_pkg::OP_BLINK, 3'd1, 3'd1, 9'd0));
		send_item(make_item(lmbs_pkg::OP_BLINK, 3'd0, 3'd1, 9'd500));
		send_item(make_item(lmbs_pkg::OP_BLINK, 3'd2, 3'd0, 9'h1FF));
		repeat (5) send_item(make_item(lmbs_pkg::OP_TICK, 3'd0, 3'd1, 9'd0));
		send_item(make_item(lmbs_pkg::OP_STOP, 3'd0, 3'd1, 9'd0));
		send_item(make_item(lmbs_pkg::OP_TICK, 3'd5, 3'd6, 9'h1FF));
		repeat (5) send_item(make_item(lmbs_pkg::OP_TICK, 3'd1, 3'd1, 9'd0));
	endtask

	task automatic test_prescale_limits();
		write_prescale(8'd0);
		repeat (4) send_item(make_item(lmbs_pkg::OP_TICK, 3'd2, 3'd1, 9'd0));
		send_item(make_item(lmbs_pkg::OP_BLINK, 3'd2, 3'd1, 9'd3));
		write_prescale(8'd255);
		send_item(make_item(lmbs_pkg::OP_BLINK, 3'd1, 3'd0, 9'd500));
		repeat (3) send_item(make_item(lmbs_pkg::OP_TICK, 3'd1, 3'd0, 9'd0));
		write_prescale(8'd10);
		repeat (6) send_item(make_item(lmbs_pkg::OP_TICK, 3'd0, 3'd0, 9'd0));
		// lower the prescale below the running count
		write_prescale(8'd2);
		repeat (2) send_item(make_item(lmbs_pkg::OP_TICK, 3'd0, 3'd0, 9'd0));
	endtask

	task automatic test_output_backpressure();
		write_prescale(8'd1);
		@(posedge clk);
		rx_hold = LONG_HOLD;
		@(negedge clk);
		for (int i = 0; i < 12; i++)
			send_item(random_item());
		wait_drained();
		for (int i = 0; i < 8; i++)
			send_item(random_item());
	endtask

	task automatic test_random_traffic();
		run_phase(8'd1, 150);
		run_phase(8'd2, 140);
		run_phase(8'd3, 120);
		run_phase(8'd255, 60);
		run_phase(8'($urandom_range(4, 12)), 120);
		@(posedge clk);
		quiet = 1'b1;
		@(negedge clk);
		run_phase(8'd1, 150);
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		for (int r = 0; r < lmbs_pkg::ROWS; r++) begin
			m_lit[r] = 8'd0;
			for (int c = 0; c < lmbs_pkg::COLS; c++) begin
				m_blink[r][c]  = 1'b0;
				m_reload[r][c] = 9'd0;
				m_count[r][c]  = 9'd0;
			end
		end
		m_scan     = 0;
		m_precnt   = 8'd0;
		m_prescale = lmbs_pkg::PRESCALE_INIT;
		m_row_pins = 8'd0;
		m_col_pins = 8'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_led_commands();
		test_prescale_limits();
		test_output_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lmbs_pkg.sv
rtl/lmbs_div.sv
rtl/lmbs_cell.sv
rtl/led_matrix_blink_scanner.sv
dv/tb.sv
